@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by bud_core. They are empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

@@ rtl/bud_pkg.sv @@
// ----------------------------------------------------------------------------
// bud_pkg
// Types and constants of the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bud_pkg;
  localparam int MAX_ORDER = 12;
  localparam int SLOTS     = 4096;
  localparam int SLOT_W    = 12;
  localparam int ORD_W     = 4;
  localparam int OFF_W     = 28;

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic [1:0] REG_BBL = 2'd0;
  localparam logic [1:0] REG_TOP = 2'd1;
  localparam logic [1:0] REG_HDR = 2'd2;

  localparam logic [4:0] BBL_MIN = 5'd3;
  localparam logic [4:0] BBL_MAX = 5'd16;

  // One slot of the pool: block head, free mark and block order
  typedef struct packed {
    logic             head;
    logic             free;
    logic [ORD_W-1:0] order;
  } entry_t;

  // Effective geometry handed to the core
  typedef struct packed {
    logic [4:0]       bbl;
    logic [ORD_W-1:0] top;
    logic [6:0]       hdr;
    logic             fmt;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_A_SIZE, S_A_RD, S_A_CHK, S_A_SPLIT,
    S_F_SUB, S_F_CHK, S_F_RD, S_F_VAL, S_M_RD, S_M_CHK, S_M_FIN, S_FAIL
  } state_t;
endpackage
`default_nettype wire

@@ rtl/buddy_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_allocator_unit
// Binary buddy allocator with an APB register port.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; its result appears
// on status and alloc_offset with done, which is high for a single cycle, and
// cannot be stalled. Every word goes through one slot memory (4096 slots,
// one read and one write port): an allocate sizes the block, reads and checks
// slots for a free block, splits one level per step and claims the block; a
// free checks the offset, reads the slot and one buddy per merge level. done
// is registered, rising in the cycle after the last step. After reset and after
// a write of basic_block_log2 or top_order all 4096 slots are cleared, busy high.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_allocator_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       cmd,
  input  wire logic [bud_pkg::OFF_W-1:0]  req_length,
  input  wire logic [bud_pkg::OFF_W-1:0]  user_offset,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [bud_pkg::OFF_W-1:0]       alloc_offset
);
  logic [4:0] bbl_reg;
  logic [3:0] top_reg;
  logic [6:0] hdr_reg;
  logic       fmt;
  logic       we;
  bud_pkg::cfg_t cfg;

  assign pready = 1'b1;
  assign we     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bbl_reg <= 5'd7;
      top_reg <= 4'd12;
      hdr_reg <= 7'd16;
      fmt     <= 1'b0;
    end else begin
      fmt <= we && (paddr[3:2] == bud_pkg::REG_BBL || paddr[3:2] == bud_pkg::REG_TOP);
      if (we) begin
        case (paddr[3:2])
          bud_pkg::REG_BBL: bbl_reg <= pwdata[4:0];
          bud_pkg::REG_TOP: top_reg <= pwdata[3:0];
          bud_pkg::REG_HDR: hdr_reg <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      bud_pkg::REG_BBL: prdata = 32'(bbl_reg);
      bud_pkg::REG_TOP: prdata = 32'(top_reg);
      bud_pkg::REG_HDR: prdata = 32'(hdr_reg);
      default:          prdata = '0;
    endcase
  end

  // Saturate geometry into range
  always_comb begin
    if (bbl_reg < bud_pkg::BBL_MIN) cfg.bbl = bud_pkg::BBL_MIN;
    else if (bbl_reg > bud_pkg::BBL_MAX) cfg.bbl = bud_pkg::BBL_MAX;
    else cfg.bbl = bbl_reg;
    cfg.top = (top_reg > 4'(bud_pkg::MAX_ORDER)) ? 4'(bud_pkg::MAX_ORDER) : top_reg;
    cfg.hdr = hdr_reg;
    cfg.fmt = fmt;
  end

  bud_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .busy(busy), .cmd(cmd),
    .req_length(req_length), .user_offset(user_offset), .done(done),
    .status(status), .alloc_offset(alloc_offset)
  );
endmodule
`default_nettype wire

@@ rtl/bud_core.sv @@
// ----------------------------------------------------------------------------
// bud_core
// Sequencer over the slot memory: clearing pass, allocate search and split,
// free check and buddy merge. One memory read and one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bud_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bud_pkg::cfg_t              cfg,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       cmd,
  input  wire logic [bud_pkg::OFF_W-1:0]  req_length,
  input  wire logic [bud_pkg::OFF_W-1:0]  user_offset,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [bud_pkg::OFF_W-1:0]       alloc_offset
);
  bud_pkg::state_t state, state_next;
  bud_pkg::entry_t mem [bud_pkg::SLOTS];
  bud_pkg::entry_t rd_data, wr_data;
  logic [bud_pkg::SLOT_W-1:0] rd_addr, wr_addr, clr_idx;
  logic wr_en;

  logic [bud_pkg::OFF_W:0]     need;
  logic [bud_pkg::OFF_W+1:0]   size;
  logic [bud_pkg::OFF_W-1:0]   uo;
  logic [bud_pkg::ORD_W-1:0]   want, k;
  logic [bud_pkg::SLOT_W:0]    s;
  logic [bud_pkg::SLOT_W:0]    nslots, s_step;
  logic [bud_pkg::SLOT_W-1:0]  buddy, lo, hi;
  logic [bud_pkg::ORD_W-1:0]   km1;
  logic                        hit, fin;
  logic [1:0]                  fin_status;
  logic [bud_pkg::OFF_W-1:0]   fin_offset;
  logic [bud_pkg::OFF_W:0]     off_full;
  logic [bud_pkg::OFF_W-1:0]   low_bits, idx;
  logic                        cmd_q;

  // Shared datapath terms
  assign nslots   = (bud_pkg::SLOT_W+1)'(1) << cfg.top;
  assign s_step   = s + ((bud_pkg::SLOT_W+1)'(1) << k);
  assign km1      = k - bud_pkg::ORD_W'(1);
  assign buddy    = s[bud_pkg::SLOT_W-1:0] ^ (bud_pkg::SLOT_W'(1) << k);
  assign lo       = (s[bud_pkg::SLOT_W-1:0] < buddy) ? s[bud_pkg::SLOT_W-1:0] : buddy;
  assign hi       = (s[bud_pkg::SLOT_W-1:0] < buddy) ? buddy : s[bud_pkg::SLOT_W-1:0];
  assign hit      = rd_data.head && rd_data.free && (rd_data.order == k);
  assign off_full = ((bud_pkg::OFF_W+1)'(s[bud_pkg::SLOT_W-1:0]) << cfg.bbl)
                    + (bud_pkg::OFF_W+1)'(cfg.hdr);
  assign low_bits = uo & ~({bud_pkg::OFF_W{1'b1}} << cfg.bbl);
  assign idx      = uo >> cfg.bbl;
  assign busy     = (state != bud_pkg::S_IDLE) || cfg.fmt;

  function automatic logic user_offset_lt_hdr();
    return uo < bud_pkg::OFF_W'(cfg.hdr);
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bud_pkg::S_IDLE: begin
        if (start) begin
          state_next = (cmd == bud_pkg::CMD_FREE) ? bud_pkg::S_F_SUB : bud_pkg::S_A_SIZE;
        end
      end
      bud_pkg::S_CLR: begin
        if (clr_idx == '1) state_next = bud_pkg::S_IDLE;
      end
      bud_pkg::S_A_SIZE: begin
        if (!((size < (bud_pkg::OFF_W+2)'(need)) && (want <= cfg.top))) begin
          state_next = (want > cfg.top) ? bud_pkg::S_FAIL : bud_pkg::S_A_RD;
        end
      end
      bud_pkg::S_A_RD: state_next = bud_pkg::S_A_CHK;
      bud_pkg::S_A_CHK: begin
        if (hit) state_next = bud_pkg::S_A_SPLIT;
        else if (s_step >= nslots && k == cfg.top) state_next = bud_pkg::S_FAIL;
        else state_next = bud_pkg::S_A_RD;
      end
      bud_pkg::S_A_SPLIT: begin
        if (k <= want) state_next = bud_pkg::S_IDLE;
      end
      bud_pkg::S_F_SUB: begin
        state_next = (user_offset_lt_hdr()) ? bud_pkg::S_FAIL : bud_pkg::S_F_CHK;
      end
      bud_pkg::S_F_CHK: begin
        if (low_bits != '0 || idx >= bud_pkg::OFF_W'(nslots)) state_next = bud_pkg::S_FAIL;
        else state_next = bud_pkg::S_F_RD;
      end
      bud_pkg::S_F_RD: state_next = bud_pkg::S_F_VAL;
      bud_pkg::S_F_VAL: begin
        state_next = (!rd_data.head || rd_data.free) ? bud_pkg::S_FAIL : bud_pkg::S_M_RD;
      end
      bud_pkg::S_M_RD: state_next = (k >= cfg.top) ? bud_pkg::S_M_FIN : bud_pkg::S_M_CHK;
      bud_pkg::S_M_CHK: state_next = hit ? bud_pkg::S_M_RD : bud_pkg::S_M_FIN;
      bud_pkg::S_M_FIN: state_next = bud_pkg::S_IDLE;
      bud_pkg::S_FAIL: state_next = bud_pkg::S_IDLE;
      default: state_next = bud_pkg::S_IDLE;
    endcase
    if (cfg.fmt) state_next = bud_pkg::S_CLR;
  end

  // Memory port and result outputs
  always_comb begin
    rd_addr    = s[bud_pkg::SLOT_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = s[bud_pkg::SLOT_W-1:0];
    wr_data    = '0;
    fin        = 1'b0;
    fin_status = bud_pkg::ST_OK;
    fin_offset = '0;
    case (state)
      bud_pkg::S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        if (clr_idx == '0) wr_data = '{head: 1'b1, free: 1'b1, order: cfg.top};
      end
      bud_pkg::S_A_SPLIT: begin
        wr_en = 1'b1;
        if (k > want) begin
          wr_addr = s[bud_pkg::SLOT_W-1:0] + (bud_pkg::SLOT_W'(1) << km1);
          wr_data = '{head: 1'b1, free: 1'b1, order: km1};
        end else begin
          wr_data    = '{head: 1'b1, free: 1'b0, order: want};
          fin        = 1'b1;
          fin_offset = off_full[bud_pkg::OFF_W-1:0];
        end
      end
      bud_pkg::S_M_RD: rd_addr = buddy;
      bud_pkg::S_M_CHK: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = hi;
        end
      end
      bud_pkg::S_M_FIN: begin
        wr_en   = 1'b1;
        wr_data = '{head: 1'b1, free: 1'b1, order: k};
        fin     = 1'b1;
      end
      bud_pkg::S_FAIL: begin
        fin        = 1'b1;
        fin_status = (cmd_q == bud_pkg::CMD_FREE) ? bud_pkg::ST_BADFREE : bud_pkg::ST_OOM;
      end
      default: ;
    endcase
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bud_pkg::S_CLR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg.fmt) clr_idx <= '0;
      else if (state == bud_pkg::S_CLR) clr_idx <= clr_idx + bud_pkg::SLOT_W'(1);
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (fin) begin
      status       <= fin_status;
      alloc_offset <= fin_offset;
    end
    case (state)
      bud_pkg::S_IDLE: begin
        cmd_q <= cmd;
        need  <= (bud_pkg::OFF_W+1)'(req_length) + (bud_pkg::OFF_W+1)'(cfg.hdr);
        size  <= (bud_pkg::OFF_W+2)'(1) << cfg.bbl;
        uo    <= user_offset;
        want  <= '0;
        s     <= '0;
      end
      bud_pkg::S_A_SIZE: begin
        if ((size < (bud_pkg::OFF_W+2)'(need)) && (want <= cfg.top)) begin
          size <= size << 1;
          want <= want + bud_pkg::ORD_W'(1);
        end else begin
          k <= want;
        end
      end
      bud_pkg::S_A_CHK: begin
        if (!hit) begin
          if (s_step >= nslots) begin
            s <= '0;
            k <= k + bud_pkg::ORD_W'(1);
          end else begin
            s <= s_step;
          end
        end
      end
      bud_pkg::S_A_SPLIT: if (k > want) k <= km1;
      bud_pkg::S_F_SUB: uo <= uo - bud_pkg::OFF_W'(cfg.hdr);
      bud_pkg::S_F_CHK: s <= (bud_pkg::SLOT_W+1)'(idx[bud_pkg::SLOT_W-1:0]);
      bud_pkg::S_F_VAL: k <= rd_data.order;
      bud_pkg::S_M_CHK: begin
        if (hit) begin
          s <= (bud_pkg::SLOT_W+1)'(lo);
          k <= k + bud_pkg::ORD_W'(1);
        end
      end
      default: ;
    endcase
  end

  `ASSERT_PROP(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `ASSERT_PROP(a_start_busy, clk, rst, (start && !busy && !cfg.fmt) |=> busy, "accepted word did not start work")
  `ASSERT_NEVER(a_clr_done, clk, rst, state == bud_pkg::S_CLR && fin, "result during clearing pass")
  `ASSERT_NEVER(a_off_fail, clk, rst, done && status != bud_pkg::ST_OK && alloc_offset != '0, "offset on failed word")
endmodule
`default_nettype wire

@@ bench/buddy_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// buddy_allocator_unit_tb
// Self-checking bench for the buddy allocator: allocate and free words are
// checked against a slot-level model of the pool kept in the bench or against
// directed expectations, over several pool geometries written through the APB port.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_allocator_unit_tb;
  import bud_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam logic [27:0] OFF_MASK = 28'hFFFFFFF;

  typedef struct {
    logic [1:0]       st;
    logic [OFF_W-1:0] off;
  } outcome_t;

  typedef struct {
    logic             op;
    logic [OFF_W-1:0] len;
    logic [OFF_W-1:0] uoff;
    bit               typed;
    logic [1:0]       st;
    logic [OFF_W-1:0] off;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_ALLOC;
  logic [OFF_W-1:0] req_length = '0;
  logic [OFF_W-1:0] user_offset = '0;
  logic done;
  logic [1:0] status;
  logic [OFF_W-1:0] alloc_offset;

  buddy_allocator_unit u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .cmd(cmd), .req_length(req_length),
    .user_offset(user_offset), .done(done), .status(status),
    .alloc_offset(alloc_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the pool and its registers
  bit             pool_head [SLOTS];
  bit             pool_free [SLOTS];
  bit [ORD_W-1:0] pool_ord  [SLOTS];
  bit [4:0] cfg_bbl = 5'd7;
  bit [3:0] cfg_top = 4'd12;
  bit [6:0] cfg_hdr = 7'd16;

  outcome_t pending_results[$];
  longint live_starts[$];
  longint last_freed = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  function automatic int unsigned eff_bbl();
    if (cfg_bbl < BBL_MIN) return BBL_MIN;
    if (cfg_bbl > BBL_MAX) return BBL_MAX;
    return cfg_bbl;
  endfunction

  function automatic int unsigned eff_top();
    return (cfg_top > MAX_ORDER) ? MAX_ORDER : cfg_top;
  endfunction

  function automatic void format_pool();
    for (int i = 0; i < SLOTS; i++) begin
      pool_head[i] = 1'b0;
      pool_free[i] = 1'b0;
      pool_ord[i]  = '0;
    end
    pool_head[0] = 1'b1;
    pool_free[0] = 1'b1;
    pool_ord[0]  = ORD_W'(eff_top());
  endfunction

  function automatic bit block_is_free(int unsigned s, int unsigned k);
    if (s >= SLOTS) return 1'b0;
    return pool_head[s] && pool_free[s] && pool_ord[s] == k;
  endfunction

  // Carve the lowest free block of the smallest fitting order
  function automatic outcome_t carve_block(logic [OFF_W-1:0] len);
    outcome_t r;
    int unsigned bbl, top, want, k, s, nslots;
    longint need, size;
    bit found;
    bbl = eff_bbl();
    top = eff_top();
    need = longint'(len) + cfg_hdr;
    size = longint'(1) << bbl;
    want = 0;
    found = 1'b0;
    s = 0;
    r.st = ST_OOM;
    r.off = '0;
    while (size < need && want <= top) begin
      size = size << 1;
      want++;
    end
    if (want > top) return r;
    nslots = 1 << top;
    for (k = want; k <= top; k++) begin
      for (s = 0; s < nslots; s += (1 << k))
        if (block_is_free(s, k)) begin
          found = 1'b1;
          break;
        end
      if (found) break;
    end
    if (!found) return r;
    while (k > want) begin
      k--;
      if (s + (1 << k) < SLOTS) begin
        pool_head[s + (1 << k)] = 1'b1;
        pool_ord[s + (1 << k)]  = ORD_W'(k);
        pool_free[s + (1 << k)] = 1'b1;
      end
    end
    pool_ord[s]  = ORD_W'(want);
    pool_free[s] = 1'b0;
    r.st = ST_OK;
    r.off = OFF_W'(((longint'(s) << bbl) + cfg_hdr) & OFF_MASK);
    return r;
  endfunction

  // Release a block and merge it with free buddies up to the top order
  function automatic outcome_t release_block(logic [OFF_W-1:0] uoff);
    outcome_t r;
    int unsigned bbl, top, s, k, b, lo, hi;
    longint blk;
    bbl = eff_bbl();
    top = eff_top();
    r.st = ST_BADFREE;
    r.off = '0;
    if (uoff < cfg_hdr) return r;
    blk = longint'(uoff) - cfg_hdr;
    if ((blk & ((longint'(1) << bbl) - 1)) != 0) return r;
    blk = blk >> bbl;
    if (blk >= (longint'(1) << top) || blk >= SLOTS) return r;
    s = 32'(blk);
    if (!pool_head[s] || pool_free[s]) return r;
    pool_free[s] = 1'b1;
    k = pool_ord[s];
    while (k < top) begin
      b = s ^ (1 << k);
      if (!block_is_free(b, k)) break;
      lo = (s < b) ? s : b;
      hi = (s < b) ? b : s;
      pool_head[hi] = 1'b0;
      pool_free[hi] = 1'b0;
      pool_ord[hi]  = '0;
      k++;
      pool_ord[lo]  = ORD_W'(k);
      pool_free[lo] = 1'b1;
      s = lo;
    end
    r.st = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result st=%0d off=%h", status, alloc_offset));
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st)
          report_mismatch($sformatf("status %0d, want %0d", status, e.st));
        if (alloc_offset !== e.off)
          report_mismatch($sformatf("alloc_offset %h, want %h", alloc_offset, e.off));
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one word and hold it until accepted; optional idle burst first
  task automatic send_word(input logic op, input logic [OFF_W-1:0] len,
                           input logic [OFF_W-1:0] uoff, input bit typed,
                           input outcome_t want);
    outcome_t got;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    req_length <= len;
    user_offset <= uoff;
    do @(posedge clk); while (busy);
    got = (op == CMD_ALLOC) ? carve_block(len) : release_block(uoff);
    pending_results.push_back(typed ? want : got);
    if (op == CMD_ALLOC && got.st == ST_OK)
      live_starts.push_back(longint'(got.off) - cfg_hdr);
  endtask

  // Drop start and let the block drain
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BBL: begin
        cfg_bbl = data[4:0];
        format_pool();
        live_starts.delete();
      end
      REG_TOP: begin
        cfg_top = data[3:0];
        format_pool();
        live_starts.delete();
      end
      default: cfg_hdr = data[6:0];
    endcase
  endtask

  // One random word: mostly frees of live blocks and fitting allocates
  task automatic random_word();
    int unsigned pick, idx;
    logic op;
    logic [OFF_W-1:0] len, uoff;
    longint region;
    outcome_t none;
    none.st = ST_OK;
    none.off = '0;
    pick = $urandom_range(0, 99);
    len = OFF_W'($urandom);
    uoff = OFF_W'($urandom);
    region = longint'(1) << (eff_bbl() + eff_top());
    if (live_starts.size() != 0 && pick < 45) begin
      op = CMD_FREE;
      idx = $urandom_range(0, live_starts.size() - 1);
      last_freed = live_starts[idx];
      uoff = OFF_W'((live_starts[idx] + cfg_hdr) & OFF_MASK);
      live_starts.delete(idx);
    end else if (pick < 53) begin
      op = CMD_FREE;
      case ($urandom_range(0, 2))
        0: uoff = OFF_W'((last_freed + cfg_hdr) & OFF_MASK);
        1: uoff = OFF_W'((last_freed + cfg_hdr + $urandom_range(1, 300)) & OFF_MASK);
        default: ;
      endcase
    end else begin
      op = CMD_ALLOC;
      if ($urandom_range(0, 9) != 0)
        len = OFF_W'($urandom_range(0,
                32'((region >> $urandom_range(0, eff_top())) & OFF_MASK)));
    end
    send_word(op, len, uoff, 1'b0, none);
  endtask

  // Register settings per phase and word counts
  int unsigned ph_bbl [6] = '{3, 31, 0, 9, 12, 5};
  int unsigned ph_top [6] = '{0, 12, 5, 6, 15, 2};
  int unsigned ph_hdr [6] = '{0, 64, 127, 33, 1, 64};
  int unsigned ph_n   [6] = '{150, 120, 300, 400, 300, 330};

  vector_t directed [12];

  initial begin
    outcome_t want;
    directed[0]  = '{CMD_ALLOC, 28'd0,         28'd0,         1, ST_OK,      28'd16};
    directed[1]  = '{CMD_FREE,  28'd0,         28'd16,        1, ST_OK,      28'd0};
    directed[2]  = '{CMD_ALLOC, 28'hFFFFFFF,   28'd0,         1, ST_OOM,     28'd0};
    directed[3]  = '{CMD_FREE,  28'd0,         28'd0,         1, ST_BADFREE, 28'd0};
    directed[4]  = '{CMD_FREE,  28'd0,         28'd17,        1, ST_BADFREE, 28'd0};
    directed[5]  = '{CMD_FREE,  28'd0,         28'd16,        1, ST_BADFREE, 28'd0};
    directed[6]  = '{CMD_ALLOC, 28'd112,       28'hFFFFFFF,   0, ST_OK,      28'd0};
    directed[7]  = '{CMD_ALLOC, 28'd113,       28'd0,         0, ST_OK,      28'd0};
    directed[8]  = '{CMD_FREE,  28'hFFFFFFF,   28'hFFFFFFF,   1, ST_BADFREE, 28'd0};
    directed[9]  = '{CMD_ALLOC, 28'd524272,    28'd0,         0, ST_OK,      28'd0};
    directed[10] = '{CMD_FREE,  28'd0,         28'd272,       0, ST_OK,      28'd0};
    directed[11] = '{CMD_FREE,  28'd0,         28'd16,        0, ST_OK,      28'd0};

    format_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset geometry
    foreach (directed[i]) begin
      want.st = directed[i].st;
      want.off = directed[i].off;
      send_word(directed[i].op, directed[i].len, directed[i].uoff,
                directed[i].typed, want);
    end

    // Random phases over several geometries
    for (int p = 0; p < 6; p++) begin
      drain();
      apb_write(REG_BBL, ph_bbl[p]);
      apb_write(REG_TOP, ph_top[p]);
      apb_write(REG_HDR, ph_hdr[p]);
      quiet = (p == 5);
      for (int n = 0; n < ph_n[p]; n++) begin
        // change the header mid-phase; the pool must survive it
        if (p == 3 && n == 200) begin
          drain();
          apb_write(REG_HDR, 32'd8);
        end
        random_word();
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/bud_pkg.sv
rtl/bud_core.sv
rtl/buddy_allocator_unit.sv
bench/buddy_allocator_unit_tb.sv
